FILE: rtl/pdm_pkg.sv
package pdm_pkg;

    localparam int TS_W      = 32;
    localparam int TPS_W     = 27;
    localparam int MODE_W    = 2;
    localparam int FREQ_W    = 34;
    localparam int DUTY_W    = 14;
    localparam int DIV_NUM_W = 46;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int OUT_W     = FREQ_W + DUTY_W + 3 * TS_W;

    localparam logic [MODE_W-1:0] MODE_RISE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FALL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

    localparam logic [TPS_W-1:0]  TPS_RESET = 27'd1000000;
    localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;
    localparam logic [6:0]        CENTI     = 7'd100;

    // One report request handed from the front to the back.
    typedef struct packed {
        logic [TS_W-1:0] total;
        logic [TS_W-1:0] count;
        logic [TS_W-1:0] period;
        logic [TS_W-1:0] high;
        logic [TS_W-1:0] low;
    } job_t;

endpackage

FILE: rtl/pdm_front.sv
module pdm_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pdm_pkg::MODE_W-1:0]  s_tuser,   // [1:0] mode
    input  logic [pdm_pkg::TS_W-1:0]    s_tdata,   // [31:0] timestamp
    output logic                        q_push,
    output pdm_pkg::job_t               q_job,
    input  logic                        q_ready
);
    import pdm_pkg::*;

    logic [TS_W-1:0] last_rise_reg, last_fall_reg;
    logic            rise_seen_reg, fall_seen_reg;
    logic [TS_W-1:0] high_reg, low_reg, period_reg;
    logic [TS_W-1:0] total_reg, count_reg;
    logic            done_reg;
    logic            accept;
    logic [TS_W-1:0] since_rise, since_fall;

    assign s_tready   = q_ready;
    assign accept     = s_tvalid && q_ready;
    assign since_rise = s_tdata - last_rise_reg;
    assign since_fall = s_tdata - last_fall_reg;
    assign q_push     = accept && (s_tuser == MODE_REPORT) && done_reg;

    always_comb begin
        q_job.total  = total_reg;
        q_job.count  = count_reg;
        q_job.period = period_reg;
        q_job.high   = high_reg;
        q_job.low    = low_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_rise_reg <= '0;
            last_fall_reg <= '0;
            rise_seen_reg <= 1'b0;
            fall_seen_reg <= 1'b0;
            high_reg      <= '0;
            low_reg       <= '0;
            period_reg    <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end else if (accept) begin
            unique case (s_tuser)
                MODE_RISE: begin
                    if (fall_seen_reg) begin
                        low_reg <= since_fall;
                    end
                    if (rise_seen_reg) begin
                        period_reg <= since_rise;
                        total_reg  <= total_reg + since_rise;
                        count_reg  <= count_reg + 1'b1;
                        done_reg   <= 1'b1;
                    end
                    last_rise_reg <= s_tdata;
                    rise_seen_reg <= 1'b1;
                end
                MODE_FALL: begin
                    if (rise_seen_reg) begin
                        high_reg <= since_rise;
                    end
                    last_fall_reg <= s_tdata;
                    fall_seen_reg <= 1'b1;
                end
                MODE_REPORT: begin
                    // clear the running average once its request is queued
                    if (done_reg) begin
                        total_reg <= '0;
                        count_reg <= '0;
                        done_reg  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/pdm_queue.sv
module pdm_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pdm_pkg::job_t push_job,
    output logic          ready,
    input  logic          pop,
    output logic          valid,
    output pdm_pkg::job_t pop_job
);
    import pdm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign ready   = (fill_reg != CNT_W'(DEPTH));
    assign valid   = (fill_reg != '0);
    assign pop_job = mem_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/pdm_div.sv
module pdm_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pdm_pkg::DIV_NUM_W-1:0] num,
    input  logic [pdm_pkg::DIV_DEN_W-1:0] den,
    output logic                          busy,
    output logic [pdm_pkg::DIV_NUM_W-1:0] quot
);
    import pdm_pkg::*;

    logic [DIV_NUM_W-1:0] work_reg;
    logic [DIV_DEN_W-1:0] rem_reg, den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W+1:0] diff;
    logic                 fits;

    // one restoring step: bring down the next numerator bit, subtract if it fits
    assign trial = {rem_reg, work_reg[DIV_NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = !diff[DIV_DEN_W+1];
    assign busy  = busy_reg;
    assign quot  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_NUM_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            work_reg <= {work_reg[DIV_NUM_W-2:0], fits};
            rem_reg  <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end
    end

endmodule

FILE: rtl/pdm_back.sv
module pdm_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pdm_pkg::TPS_W-1:0] tps,
    input  logic                      q_valid,
    input  pdm_pkg::job_t             q_job,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pdm_pkg::OUT_W-1:0] m_tdata
);
    import pdm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_AVG_W, S_FREQ, S_FREQ_W, S_DUTY, S_DUTY_W
    } state_t;

    state_t               state_reg;
    job_t                 job_reg;
    logic [FREQ_W-1:0]    freq_num_reg;
    logic [DIV_NUM_W-1:0] duty_num_reg;
    logic [TS_W-1:0]      avg_reg;
    logic [FREQ_W-1:0]    freq_reg;
    logic                 m_tvalid_reg;
    logic [FREQ_W-1:0]    m_freq_reg;
    logic [DUTY_W-1:0]    m_duty_reg;
    logic [TS_W-1:0]      m_period_reg, m_high_reg, m_low_reg;

    logic                 div_start, div_busy;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 out_free;
    logic                 out_load;
    logic [DUTY_W-1:0]    duty_sat;

    pdm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_DUTY_W) && !div_busy && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_low_reg, m_high_reg, m_period_reg, m_duty_reg, m_freq_reg};
    assign duty_sat = (div_quot > DIV_NUM_W'(DUTY_FULL)) ? DUTY_FULL
                                                          : div_quot[DUTY_W-1:0];

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_MUL: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(job_reg.total);
                div_den   = job_reg.count;
            end
            S_FREQ: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(freq_num_reg);
                div_den   = avg_reg;
            end
            S_DUTY: begin
                div_start = 1'b1;
                div_num   = duty_num_reg;
                div_den   = job_reg.period;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        job_reg   <= q_job;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    freq_num_reg <= FREQ_W'(tps) * FREQ_W'(CENTI);
                    duty_num_reg <= DIV_NUM_W'(job_reg.high) * DIV_NUM_W'(DUTY_FULL);
                    state_reg    <= S_AVG_W;
                end
                S_AVG_W: begin
                    if (!div_busy) begin
                        avg_reg   <= (job_reg.count == '0) ? '0 : div_quot[TS_W-1:0];
                        state_reg <= S_FREQ;
                    end
                end
                S_FREQ: begin
                    state_reg <= S_FREQ_W;
                end
                S_FREQ_W: begin
                    if (!div_busy) begin
                        freq_reg  <= (avg_reg == '0) ? '0 : div_quot[FREQ_W-1:0];
                        state_reg <= S_DUTY;
                    end
                end
                S_DUTY: begin
                    state_reg <= S_DUTY_W;
                end
                S_DUTY_W: begin
                    if (out_load) begin
                        m_freq_reg   <= freq_reg;
                        m_duty_reg   <= (job_reg.period == '0) ? '0 : duty_sat;
                        m_period_reg <= job_reg.period;
                        m_high_reg   <= job_reg.high;
                        m_low_reg    <= job_reg.low;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_duty_reg <= DUTY_FULL))
        else $error("duty above full scale");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DUTY_W))
        else $error("result raised outside the duty step");

    a_pop_start: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == S_MUL))
        else $error("popped request not started");
`endif

endmodule

FILE: rtl/pwm_period_duty_meter.sv
// PWM period and duty meter.
// Input stream (s_*): one request per accepted beat. s_tuser carries the kind
// (rising edge, falling edge, report tick), s_tdata the 32-bit tick timestamp.
// Edges update the period, high and low measurements as they are accepted, so edge
// requests are taken every cycle while the report queue has room.
// A report tick after a completed rise-to-rise cycle queues one report request
// and clears the running period total and count; a tick without one is dropped.
// Result stream (m_*): frequency in centihertz, duty in basis points and the
// latest period, high and low times. Between acceptance and m_tvalid a report
// runs three 46-bit divisions in turn on one shared radix-2 divider (average
// period, frequency, duty).
// While the receiver stalls, the finished result waits in the output register,
// the back end holds its next report, edges keep flowing, and s_tready falls
// only once QUEUE_DEPTH reports are waiting.
// APB port: ticks_per_second at address 0, written on psel & penable & pwrite,
// readable; write it only while the meter is idle.
// Reset (aresetn low, synchronous) clears all measurements, the queue and the
// output, and sets ticks_per_second to 1000000.
module pwm_period_duty_meter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [1:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // edge and report requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pdm_pkg::MODE_W-1:0]     s_tuser,   // [1:0] mode
    input  logic [pdm_pkg::TS_W-1:0]       s_tdata,   // [31:0] timestamp
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [33:0] frequency_centihz, [47:34] duty_basis_points, [79:48] period_ticks,
    // [111:80] high_ticks, [143:112] low_ticks
    output logic [pdm_pkg::OUT_W-1:0]      m_tdata
);
    import pdm_pkg::*;

    logic [TPS_W-1:0] tps_reg;
    logic             q_push, q_ready, q_pop, q_valid;
    job_t             push_job, pop_job;

    // Single register: every address maps to ticks_per_second.
    assign pready = 1'b1;
    assign prdata = 32'(tps_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= TPS_RESET;
        end else if (psel && penable && pwrite) begin
            tps_reg <= pwdata[TPS_W-1:0];
        end
    end

    // Front: classify requests and keep the edge measurements.
    pdm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_job    (push_job),
        .q_ready  (q_ready)
    );

    // Hold report snapshots between the front and the divider back end.
    pdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (pop_job)
    );

    // Back: run the divisions and drive the result register.
    pdm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tps      (tps_reg),
        .q_valid  (q_valid),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
